// ===== hw/rtl/sph_pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator package
// Beat types, micro-operation codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sph_pfa_pkg;

  // largest magnitude carried by any intermediate value
  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [3:0] CFG_KERNEL_RADIUS   = 4'd0;
  localparam logic [3:0] CFG_PARTICLE_MASS   = 4'd1;
  localparam logic [3:0] CFG_VISCOSITY_CONST = 4'd2;
  localparam logic [3:0] CFG_PRESSURE_COEF   = 4'd3;
  localparam logic [3:0] CFG_VISCOSITY_COEF  = 4'd4;
  localparam logic [3:0] CFG_WALL_STRENGTH   = 4'd5;
  localparam logic [3:0] CFG_WALL_CUTOFF     = 4'd6;
  localparam logic [3:0] CFG_GRAVITY_Y       = 4'd7;

  // input beat
  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] nbr_vel_x;
    logic signed [31:0] nbr_vel_y;
    logic        [31:0] nbr_density;
    logic signed [47:0] nbr_pressure;
    logic               nbr_is_wall;
    logic signed [31:0] own_vel_x;
    logic signed [31:0] own_vel_y;
    logic        [31:0] own_density;
    logic signed [47:0] own_pressure;
    logic               last_neighbor;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic               saturated;
  } out_item_t;

  // configuration write beat
  typedef struct packed {
    logic [3:0]  index;
    logic [47:0] data;
  } cfg_write_t;

  // micro-operations; linear chains are consecutive codes
  typedef enum logic [4:0] {
    OP_DX2, OP_DY2, OP_SQRT, OP_UX, OP_UY,
    OP_Q, OP_A, OP_K, OP_G, OP_MAG, OP_PX, OP_PY, OP_L,
    OP_WX, OP_WXM, OP_WXV, OP_VX, OP_WY, OP_WYM, OP_WYV, OP_VY,
    OP_S, OP_S2, OP_S4, OP_E, OP_IR, OP_EX, OP_WLX, OP_EY, OP_WLY,
    OP_GRAV
  } op_t;

  // product scaling
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_40 = 2'd2
  } shift_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic start;
    op_t  op;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic r_zero;
    logic fluid_ok;
    logic wall_ok;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/sph_pfa_stream_if.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator stream interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface sph_pfa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sph_pair_force_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator
// Pressure, viscosity and wall force sums over the neighbours of a particle.
// ----------------------------------------------------------------------------
// One input beat is one neighbour pair; pairs are taken one at a time and a
// result beat follows only the pair marked last. A pair whose distance is
// zero runs the two squares and a 32-step square root; one that lies outside
// the kernel or wall radius adds two divisions for the unit vector; a wall
// pair and a fluid pair go on to their force terms. The last pair adds
// gravity and the emit, which waits while the result register is still held
// by the sink. The divider is bit-serial: a quotient takes 64 restoring
// steps, and a product takes four partial products on one shared 32x32
// multiplier. Configuration writes are accepted at any time and must only
// be made while the block is idle.
module sph_pair_force_accumulator_unit (
  input  logic             clk,
  input  logic             rst_n,
  sph_pfa_stream_if.sink   in_ch,
  sph_pfa_stream_if.source out_ch,
  sph_pfa_stream_if.sink   cfg_ch
);

  sph_pfa_pkg::cmd_t cmd;
  sph_pfa_pkg::sts_t sts;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  sph_pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sph_pfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_ch.payload),
    .cfg_we    (cfg_ch.valid),
    .cfg       (cfg_ch.payload),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.payload)
  );

  // a unit never reports completion in the cycle it is started
  a_start_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !sts.done)
    else $error("unit done while a step is issued");

  // an accepted pair starts its first step next cycle
  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd.start)
    else $error("accepted pair did not start");

  // emit only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit into occupied output register");

  // an emit shows a result beat next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emit without result beat");

endmodule

// ===== hw/rtl/sph_pfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator controller
// Sequences the micro-operations of one pair and the emit of a result.
// ----------------------------------------------------------------------------
module sph_pfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output sph_pfa_pkg::cmd_t  cmd,
  input  sph_pfa_pkg::sts_t  sts
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ISSUE  = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_BRANCH = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  sph_pfa_pkg::op_t step_r, step_nxt;

  // next state and step
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.op      = step_r;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          step_nxt  = sph_pfa_pkg::OP_DX2;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.done) state_nxt = ST_BRANCH;
      end
      ST_BRANCH: begin
        state_nxt = ST_ISSUE;
        case (step_r)
          sph_pfa_pkg::OP_SQRT: begin
            if (sts.r_zero) begin
              if (sts.last) step_nxt = sph_pfa_pkg::OP_GRAV;
              else state_nxt = ST_IDLE;
            end else begin
              step_nxt = sph_pfa_pkg::OP_UX;
            end
          end
          sph_pfa_pkg::OP_UY: begin
            if (sts.fluid_ok) step_nxt = sph_pfa_pkg::OP_Q;
            else if (sts.wall_ok) step_nxt = sph_pfa_pkg::OP_S;
            else if (sts.last) step_nxt = sph_pfa_pkg::OP_GRAV;
            else state_nxt = ST_IDLE;
          end
          sph_pfa_pkg::OP_VY, sph_pfa_pkg::OP_WLY: begin
            if (sts.last) step_nxt = sph_pfa_pkg::OP_GRAV;
            else state_nxt = ST_IDLE;
          end
          sph_pfa_pkg::OP_GRAV: begin
            state_nxt = ST_EMIT;
          end
          default: begin
            step_nxt = sph_pfa_pkg::op_t'(step_r + 5'd1);
          end
        endcase
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= sph_pfa_pkg::OP_DX2;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== hw/rtl/sph_pfa_mul.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator multiplier
// Signed 64x64 product from four 32x32 partial products, scaled and clamped.
// ----------------------------------------------------------------------------
module sph_pfa_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  input  sph_pfa_pkg::shift_t  sel,
  output logic                 done,
  output logic signed [63:0]   y
);

  logic                busy_r;
  logic [2:0]          cnt_r;
  logic [63:0]         ma_r, mb_r;
  logic                neg_r;
  sph_pfa_pkg::shift_t sel_r;
  logic [127:0]        acc_r;
  logic                done_r;
  logic signed [63:0]  y_r;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh, scaled;
  logic [63:0]  mag;

  // partial product for the current step
  always_comb begin
    a_part = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    b_part = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp     = a_part * b_part;
    case ({cnt_r[1], cnt_r[0]})
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // scale, clamp
  always_comb begin
    case (sel_r)
      sph_pfa_pkg::SH_16: scaled = acc_r >> 16;
      sph_pfa_pkg::SH_40: scaled = acc_r >> 40;
      default:            scaled = acc_r;
    endcase
    if ((|scaled[127:64]) || scaled[63]) mag = sph_pfa_pkg::MAG_MAX;
    else mag = scaled[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= a[63] ? 64'(-a) : 64'(a);
      mb_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= a[63] ^ b[63];
      sel_r <= sel;
      acc_r <= '0;
    end else if (busy_r && cnt_r != 3'd4) begin
      acc_r <= acc_r + pp_sh;
    end
    if (busy_r && cnt_r == 3'd4) begin
      y_r <= neg_r ? -$signed(mag) : $signed(mag);
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

// ===== hw/rtl/sph_pfa_div.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator divider
// Restoring divider, one quotient bit a cycle, truncated and clamped.
// ----------------------------------------------------------------------------
module sph_pfa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         num,
  input  logic [31:0]         den,
  input  logic                neg,
  output logic                done,
  output logic signed [63:0]  y
);

  logic               busy_r;
  logic [6:0]         cnt_r;
  logic [63:0]        quo_r;
  logic [31:0]        rem_r, den_r;
  logic               neg_r;
  logic               done_r;
  logic signed [63:0] y_r;

  logic [32:0] trial, diff;
  logic        fits;
  logic [63:0] mag;

  // one restoring step
  always_comb begin
    trial = {rem_r, quo_r[63]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
    mag   = quo_r[63] ? sph_pfa_pkg::MAG_MAX : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 7'd64) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  // quotient shifts in where the numerator shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r && cnt_r != 7'd64) begin
      rem_r <= fits ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[62:0], fits};
    end
    if (busy_r && cnt_r == 7'd64) begin
      y_r <= neg_r ? -$signed(mag) : $signed(mag);
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

// ===== hw/rtl/sph_pfa_dp.sv =====
// ----------------------------------------------------------------------------
// SPH pair force accumulator datapath
// Registers, operand routing, square root, shared units and force sums.
// ----------------------------------------------------------------------------
module sph_pfa_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sph_pfa_pkg::cmd_t       cmd,
  output sph_pfa_pkg::sts_t       sts,
  input  sph_pfa_pkg::in_item_t   in_item,
  input  logic                    cfg_we,
  input  sph_pfa_pkg::cfg_write_t cfg,
  input  logic                    out_ready,
  output logic                    out_valid,
  output sph_pfa_pkg::out_item_t  out_item
);

  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [63:0] F48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] F48_MIN = -64'sh0000_8000_0000_0000;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SUM_MAX) return SUM_MAX[63:0];
    if (s < SUM_MIN) return SUM_MIN[63:0];
    return s[63:0];
  endfunction

  // configuration registers
  logic [31:0]        kernel_radius_r, particle_mass_r, viscosity_const_r;
  logic signed [47:0] pressure_coef_r, viscosity_coef_r;
  logic [31:0]        wall_strength_r, wall_cutoff_r;
  logic signed [31:0] gravity_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_radius_r   <= 32'd655360;
      particle_mass_r   <= 32'd4259840;
      viscosity_const_r <= 32'd3932160;
      pressure_coef_r   <= -48'sd15749343;
      viscosity_coef_r  <= 48'sd15749343;
      wall_strength_r   <= 32'd163840000;
      wall_cutoff_r     <= 32'd655360;
      gravity_y_r       <= -32'sd6429082;
    end else if (cfg_we) begin
      case (cfg.index)
        sph_pfa_pkg::CFG_KERNEL_RADIUS:   kernel_radius_r   <= cfg.data[31:0];
        sph_pfa_pkg::CFG_PARTICLE_MASS:   particle_mass_r   <= cfg.data[31:0];
        sph_pfa_pkg::CFG_VISCOSITY_CONST: viscosity_const_r <= cfg.data[31:0];
        sph_pfa_pkg::CFG_PRESSURE_COEF:   pressure_coef_r   <= cfg.data;
        sph_pfa_pkg::CFG_VISCOSITY_COEF:  viscosity_coef_r  <= cfg.data;
        sph_pfa_pkg::CFG_WALL_STRENGTH:   wall_strength_r   <= cfg.data[31:0];
        sph_pfa_pkg::CFG_WALL_CUTOFF:     wall_cutoff_r     <= cfg.data[31:0];
        sph_pfa_pkg::CFG_GRAVITY_Y:       gravity_y_r       <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // captured pair and working registers
  sph_pfa_pkg::in_item_t item_r;
  sph_pfa_pkg::op_t      cur_op_r;
  logic [31:0]           r_r;
  logic signed [63:0]    ta_r, tb_r, tc_r, ux_r, uy_r;
  logic signed [63:0]    acc_x_r, acc_y_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.start) cur_op_r <= cmd.op;
  end

  // derived operands
  logic [31:0]        u32, mdx, mdy;
  logic signed [48:0] psum;
  logic [48:0]        mpsum;
  logic signed [32:0] dvx, dvy;
  logic [32:0]        mdvx, mdvy;
  logic signed [63:0] u64, mass64, visc64;

  always_comb begin
    u32    = kernel_radius_r - r_r;
    u64    = $signed({32'd0, u32});
    mass64 = $signed({32'd0, particle_mass_r});
    visc64 = $signed({32'd0, viscosity_const_r});
    mdx    = item_r.offset_x[31] ? 32'(-item_r.offset_x) : 32'(item_r.offset_x);
    mdy    = item_r.offset_y[31] ? 32'(-item_r.offset_y) : 32'(item_r.offset_y);
    psum   = {item_r.nbr_pressure[47], item_r.nbr_pressure}
           + {item_r.own_pressure[47], item_r.own_pressure};
    mpsum  = psum[48] ? 49'(-psum) : 49'(psum);
    dvx    = {item_r.nbr_vel_x[31], item_r.nbr_vel_x}
           - {item_r.own_vel_x[31], item_r.own_vel_x};
    dvy    = {item_r.nbr_vel_y[31], item_r.nbr_vel_y}
           - {item_r.own_vel_y[31], item_r.own_vel_y};
    mdvx   = dvx[32] ? 33'(-dvx) : 33'(dvx);
    mdvy   = dvy[32] ? 33'(-dvy) : 33'(dvy);
  end

  // operand routing for the issued step
  logic                mul_go, div_go, sq_go;
  logic signed [63:0]  mul_a, mul_b;
  sph_pfa_pkg::shift_t mul_sel;
  logic [63:0]         div_num;
  logic [31:0]         div_den;
  logic                div_neg;

  always_comb begin
    mul_go  = 1'b0;
    div_go  = 1'b0;
    sq_go   = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_sel = sph_pfa_pkg::SH_16;
    div_num = '0;
    div_den = r_r;
    div_neg = 1'b0;
    if (cmd.start) begin
      mul_go = 1'b1;
      case (cmd.op)
        sph_pfa_pkg::OP_DX2: begin
          mul_a = $signed({32'd0, mdx}); mul_b = mul_a; mul_sel = sph_pfa_pkg::SH_0;
        end
        sph_pfa_pkg::OP_DY2: begin
          mul_a = $signed({32'd0, mdy}); mul_b = mul_a; mul_sel = sph_pfa_pkg::SH_0;
        end
        sph_pfa_pkg::OP_A:   begin mul_a = ta_r; mul_b = mass64; end
        sph_pfa_pkg::OP_K:   begin mul_a = u64;  mul_b = u64; end
        sph_pfa_pkg::OP_G: begin
          mul_a = tb_r; mul_b = 64'(pressure_coef_r); mul_sel = sph_pfa_pkg::SH_40;
        end
        sph_pfa_pkg::OP_MAG: begin mul_a = ta_r; mul_b = tb_r; end
        sph_pfa_pkg::OP_PX:  begin mul_a = ta_r; mul_b = ux_r; end
        sph_pfa_pkg::OP_PY:  begin mul_a = ta_r; mul_b = uy_r; end
        sph_pfa_pkg::OP_L: begin
          mul_a = u64; mul_b = 64'(viscosity_coef_r); mul_sel = sph_pfa_pkg::SH_40;
        end
        sph_pfa_pkg::OP_WXM, sph_pfa_pkg::OP_WYM: begin
          mul_a = tc_r; mul_b = mass64;
        end
        sph_pfa_pkg::OP_WXV, sph_pfa_pkg::OP_WYV: begin
          mul_a = tc_r; mul_b = visc64;
        end
        sph_pfa_pkg::OP_VX, sph_pfa_pkg::OP_VY: begin
          mul_a = tc_r; mul_b = tb_r;
        end
        sph_pfa_pkg::OP_S2:  begin mul_a = ta_r; mul_b = ta_r; end
        sph_pfa_pkg::OP_S4:  begin mul_a = tb_r; mul_b = tb_r; end
        sph_pfa_pkg::OP_E: begin
          mul_a = ta_r - tb_r; mul_b = $signed({32'd0, wall_strength_r});
        end
        sph_pfa_pkg::OP_EX:  begin mul_a = ta_r; mul_b = ux_r; end
        sph_pfa_pkg::OP_EY:  begin mul_a = ta_r; mul_b = uy_r; end
        sph_pfa_pkg::OP_WLX, sph_pfa_pkg::OP_WLY: begin
          mul_a = tc_r; mul_b = tb_r;
        end
        sph_pfa_pkg::OP_GRAV: begin
          mul_a = 64'(gravity_y_r); mul_b = $signed({32'd0, item_r.own_density});
        end
        sph_pfa_pkg::OP_SQRT: begin
          mul_go = 1'b0; sq_go = 1'b1;
        end
        sph_pfa_pkg::OP_UX: begin
          mul_go = 1'b0; div_go = 1'b1;
          div_num = {16'd0, mdx, 16'd0}; div_neg = item_r.offset_x[31];
        end
        sph_pfa_pkg::OP_UY: begin
          mul_go = 1'b0; div_go = 1'b1;
          div_num = {16'd0, mdy, 16'd0}; div_neg = item_r.offset_y[31];
        end
        sph_pfa_pkg::OP_Q: begin
          mul_go = 1'b0; div_go = 1'b1; div_den = item_r.nbr_density;
          div_num = {mpsum, 15'd0}; div_neg = psum[48];
        end
        sph_pfa_pkg::OP_WX: begin
          mul_go = 1'b0; div_go = 1'b1; div_den = item_r.nbr_density;
          div_num = {15'd0, mdvx, 16'd0}; div_neg = dvx[32];
        end
        sph_pfa_pkg::OP_WY: begin
          mul_go = 1'b0; div_go = 1'b1; div_den = item_r.nbr_density;
          div_num = {15'd0, mdvy, 16'd0}; div_neg = dvy[32];
        end
        sph_pfa_pkg::OP_S: begin
          mul_go = 1'b0; div_go = 1'b1;
          div_num = {16'd0, wall_cutoff_r, 16'd0};
        end
        sph_pfa_pkg::OP_IR: begin
          mul_go = 1'b0; div_go = 1'b1;
          div_num = 64'h0000_0001_0000_0000;
        end
        default: mul_go = 1'b0;
      endcase
    end
  end

  // shared units
  logic               mul_done, div_done;
  logic signed [63:0] mul_y, div_y, wb;

  sph_pfa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .sel   (mul_sel),
    .done  (mul_done),
    .y     (mul_y)
  );

  sph_pfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .neg   (div_neg),
    .done  (div_done),
    .y     (div_y)
  );

  assign wb = mul_done ? mul_y : div_y;

  // square root, two radicand bits a cycle
  logic        sq_busy_r, sq_done_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r, sq_trial, sq_res_nxt;

  always_comb begin
    sq_trial   = sq_res_r + sq_bit_r;
    sq_res_nxt = (sq_v_r >= sq_trial) ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
    end else begin
      sq_done_r <= 1'b0;
      if (sq_go) begin
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r && sq_bit_r == 64'd1) begin
        sq_busy_r <= 1'b0;
        sq_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_go) begin
      sq_v_r   <= ta_r + tb_r;
      sq_res_r <= '0;
      sq_bit_r <= 64'h4000_0000_0000_0000;
    end else if (sq_busy_r) begin
      if (sq_v_r >= sq_trial) sq_v_r <= sq_v_r - sq_trial;
      sq_res_r <= sq_res_nxt;
      sq_bit_r <= sq_bit_r >> 2;
      if (sq_bit_r == 64'd1) r_r <= sq_res_nxt[31:0];
    end
  end

  // clamp the sums to the result width
  logic signed [63:0] acc_y_emit;
  logic               sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo;
  logic signed [47:0] fx, fy;

  always_comb begin
    acc_y_emit = acc_y_r;
    sat_x_hi   = acc_x_r > F48_MAX;
    sat_x_lo   = acc_x_r < F48_MIN;
    sat_y_hi   = acc_y_emit > F48_MAX;
    sat_y_lo   = acc_y_emit < F48_MIN;
    fx = sat_x_hi ? F48_MAX[47:0] : (sat_x_lo ? F48_MIN[47:0] : acc_x_r[47:0]);
    fy = sat_y_hi ? F48_MAX[47:0] : (sat_y_lo ? F48_MIN[47:0] : acc_y_emit[47:0]);
  end

  // writeback and force sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (cmd.emit) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (mul_done || div_done) begin
      case (cur_op_r)
        sph_pfa_pkg::OP_PX, sph_pfa_pkg::OP_VX, sph_pfa_pkg::OP_WLX:
          acc_x_r <= sat_add(acc_x_r, wb);
        sph_pfa_pkg::OP_PY, sph_pfa_pkg::OP_VY, sph_pfa_pkg::OP_WLY,
        sph_pfa_pkg::OP_GRAV:
          acc_y_r <= sat_add(acc_y_r, wb);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_done || div_done) begin
      case (cur_op_r)
        sph_pfa_pkg::OP_DX2, sph_pfa_pkg::OP_Q, sph_pfa_pkg::OP_A,
        sph_pfa_pkg::OP_MAG, sph_pfa_pkg::OP_S, sph_pfa_pkg::OP_S4,
        sph_pfa_pkg::OP_E:
          ta_r <= wb;
        sph_pfa_pkg::OP_DY2, sph_pfa_pkg::OP_K, sph_pfa_pkg::OP_G,
        sph_pfa_pkg::OP_L, sph_pfa_pkg::OP_S2, sph_pfa_pkg::OP_IR:
          tb_r <= wb;
        sph_pfa_pkg::OP_WX, sph_pfa_pkg::OP_WXM, sph_pfa_pkg::OP_WXV,
        sph_pfa_pkg::OP_WY, sph_pfa_pkg::OP_WYM, sph_pfa_pkg::OP_WYV,
        sph_pfa_pkg::OP_EX, sph_pfa_pkg::OP_EY:
          tc_r <= wb;
        sph_pfa_pkg::OP_UX: ux_r <= wb;
        sph_pfa_pkg::OP_UY: uy_r <= wb;
        default: ;
      endcase
    end
  end

  // output register
  logic                   out_valid_r;
  sph_pfa_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.force_x   <= fx;
      out_item_r.force_y   <= fy;
      out_item_r.saturated <= sat_x_hi | sat_x_lo | sat_y_hi | sat_y_lo;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // status
  always_comb begin
    sts.done     = mul_done | div_done | sq_done_r;
    sts.r_zero   = (r_r == 32'd0);
    sts.fluid_ok = !item_r.nbr_is_wall && (item_r.nbr_density != 32'd0)
                 && (r_r < kernel_radius_r);
    sts.wall_ok  = item_r.nbr_is_wall && (r_r < wall_cutoff_r);
    sts.last     = item_r.last_neighbor;
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule
